[src/cfsh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsh_pkg : shared definitions for the case-folding string hash
// Widths, hash constants, sequencer codes and the character fold function.
// ----------------------------------------------------------------------------
package cfsh_pkg;

    localparam int CHAR_W   = 16;
    localparam int ACC_W    = 32;
    localparam int BKT_W    = 16;
    localparam int DIV_STEPS = ACC_W;
    localparam int STEP_W   = $clog2(DIV_STEPS + 1);

    localparam logic [ACC_W-1:0]  HASH_BASE  = ACC_W'(11);
    localparam logic [CHAR_W-1:0] FOLD_DELTA = CHAR_W'(8'h61 - 8'h41);
    localparam logic [CHAR_W-1:0] LOWER_A    = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0] LOWER_Z    = CHAR_W'(8'h7a);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NEG  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    typedef logic [ACC_W-1:0]  t_acc;
    typedef logic [BKT_W-1:0]  t_bucket;
    typedef logic [CHAR_W-1:0] t_char;

    // lower-case ASCII letters map to upper case, all else passes
    function automatic t_char fold_char(input t_char c);
        t_char r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            r = c - FOLD_DELTA;
        end
        return r;
    endfunction

endpackage

[src/case_folding_string_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// case_folding_string_hash : base-11 string hash with case folding
// Hashes a stream of 16-bit characters and reduces the magnitude of the
// signed hash modulo a programmable table size into a bucket index.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one transfer per character. tdata holds the
//   character code, tuser flags that tdata carries a character, tlast ends
//   the string. A transfer with tuser low and tlast high ends a string with
//   no further character (empty string gives bucket 0). tuser and tlast
//   both low is an idle transfer and changes nothing.
//   Output stream (m_axis_*): one transfer per finished string, tdata holds
//   the bucket index.
//   Config channel (cfg_*): writes table_size; always ready. Write only
//   while no string is being reduced or waiting on the output.
// Timing:
//   Characters that do not end a string are taken one per cycle.
//   The final transfer starts the reduction: the magnitude step, then
//   the shared restoring compare/subtract unit, one quotient bit per cycle,
//   after which the bucket shows on m_axis; s_axis_tready stays low
//   until the result is loaded into the output register. A stalled
//   receiver holds the block after the last remainder step until the
//   output register frees up.
// Reset: synchronous, active low; clears the accumulator, sets table_size
//   to 1 and empties the output register.
// ----------------------------------------------------------------------------
module case_folding_string_hash (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  cfsh_pkg::t_char         s_axis_tdata,   // [15:0] char_code
    input  logic                    s_axis_tuser,   // [0] char_valid
    input  logic                    s_axis_tlast,   // last_char
    // output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output cfsh_pkg::t_bucket       m_axis_tdata,   // [15:0] bucket
    // config write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  cfsh_pkg::t_bucket       i_cfg_data      // table_size
);
    import cfsh_pkg::*;

    logic [1:0]        r_state, n_state;
    t_acc              r_acc, n_acc;
    t_acc              r_dvd, n_dvd;
    t_bucket           r_rem, n_rem;
    logic [STEP_W-1:0] r_steps, n_steps;
    t_bucket           r_tsize;
    logic              r_out_valid, n_out_valid;
    t_bucket           r_out_data, n_out_data;

    logic              in_xfer;
    logic              out_free;
    t_acc              acc_next_char;
    logic [BKT_W:0]    trial;
    logic [BKT_W:0]    trial_sub;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // acc * 11 + folded character
    assign acc_next_char = (r_acc << 3) + (r_acc << 1) + r_acc
                         + ACC_W'(fold_char(s_axis_tdata));

    // shared remainder unit: shift in the next dividend bit, trial subtract
    assign trial     = {r_rem, r_dvd[ACC_W-1]};
    assign trial_sub = trial - {1'b0, r_tsize};

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_steps     = r_steps;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser) begin
                        n_acc = acc_next_char;
                    end
                    if (s_axis_tlast) begin
                        n_dvd   = s_axis_tuser ? acc_next_char : r_acc;
                        n_acc   = '0;
                        n_state = ST_NEG;
                    end
                end
            end
            ST_NEG: begin
                // magnitude as unsigned; -2^31 maps to 2^31
                if (r_dvd[ACC_W-1]) begin
                    n_dvd = ~r_dvd + ACC_W'(1);
                end
                n_rem   = '0;
                n_steps = STEP_W'(DIV_STEPS);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_steps != '0) begin
                    n_rem   = (trial >= {1'b0, r_tsize}) ? trial_sub[BKT_W-1:0]
                                                         : trial[BKT_W-1:0];
                    n_dvd   = r_dvd << 1;
                    n_steps = r_steps - STEP_W'(1);
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_tsize == '0) ? '0 : r_rem;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_steps     <= '0;
            r_tsize     <= BKT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tsize <= i_cfg_data;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
    end

`ifndef NO_ASSERTIONS
    // a finished string clears the accumulator
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tlast) |=> (r_acc == '0) && (r_state == ST_NEG))
        else $error("accumulator not cleared after string end");

    // magnitude step always hands over to the remainder unit with a full count
    a_neg_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NEG) |=> (r_state == ST_DIV) && (r_steps == STEP_W'(DIV_STEPS)))
        else $error("remainder unit not started correctly");

    // partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_steps != STEP_W'(DIV_STEPS) && r_tsize != '0)
            |-> (r_rem < r_tsize))
        else $error("partial remainder out of range");

    // a new result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid && $stable(r_out_data))
        else $error("pending result overwritten");
`endif

endmodule
